// File: rtl/sile_pkg.sv
// Shared types and codes for the sorted integer list engine.
package sile_pkg;

  // Command codes as they arrive on the input channel
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_MODIFY = 3'd3;
  localparam logic [2:0] CMD_SEARCH = 3'd4;
  localparam logic [2:0] CMD_DUMP   = 3'd5;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_EMPTY     = 2'd3;

  // Depth of the small queues between the parts
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_DELETE,
    OP_CLEAR,
    OP_MODIFY,
    OP_SEARCH,
    OP_DUMP
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_t;

  // Classified command handed from the front to the list engine
  typedef struct packed {
    op_t         op;
    logic [31:0] key;
    logic [31:0] new_value;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [4:0]  position;
    logic        last;
  } res_t;

endpackage

// File: rtl/sile_fifo.sv
// Two-entry register queue of generic width.
module sile_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  import sile_pkg::*;

  logic [WIDTH-1:0] mem_r [QDEPTH];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == 2'(QDEPTH));
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/sile_front.sv
// Input side: takes transfers, decodes commands and queues them for the engine.
module sile_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  logic [2:0]     in_command,
  input  logic [31:0]    in_key,
  input  logic [31:0]    in_new_value,
  output sile_pkg::cmd_t cmd_head,
  output logic           cmd_empty,
  input  logic           cmd_pop
);
  import sile_pkg::*;

  cmd_t cmd_in;
  logic known;
  logic [$bits(cmd_t)-1:0] head_bits;

  // classify; unknown codes are taken and dropped
  always_comb begin
    known        = 1'b1;
    cmd_in.op    = OP_INSERT;
    cmd_in.key   = in_key;
    cmd_in.new_value = in_new_value;
    case (in_command)
      CMD_INSERT: cmd_in.op = OP_INSERT;
      CMD_DELETE: cmd_in.op = OP_DELETE;
      CMD_CLEAR:  cmd_in.op = OP_CLEAR;
      CMD_MODIFY: cmd_in.op = OP_MODIFY;
      CMD_SEARCH: cmd_in.op = OP_SEARCH;
      CMD_DUMP:   cmd_in.op = OP_DUMP;
      default:    known = 1'b0;
    endcase
  end

  sile_fifo #(
    .WIDTH ($bits(cmd_t))
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push && known),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (head_bits),
    .empty   (cmd_empty)
  );

  assign cmd_head = cmd_t'(head_bits);

endmodule

// File: rtl/sile_back.sv
// List engine: chain of entry cells with parallel compare, shift and dump rotation.
module sile_back #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sile_pkg::cmd_t cmd_head,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  output sile_pkg::res_t res,
  output logic           res_push,
  input  logic           res_full
);
  import sile_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t state_r, state_nxt;

  logic [DATA_WIDTH-1:0] cells_r [CAPACITY];
  logic [DATA_WIDTH-1:0] cells_nxt [CAPACITY];
  logic [DATA_WIDTH-1:0] from_up [CAPACITY];
  logic [DATA_WIDTH-1:0] from_dn [CAPACITY];
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      dcnt_r, dcnt_nxt;

  op_t                   op_r;
  logic [DATA_WIDTH-1:0] key_r, nv_r;
  logic [CAPACITY-1:0]   eq_r, ge_r;

  logic [DATA_WIDTH-1:0] head_key, head_nv;
  logic [CAPACITY-1:0]   eq_n, ge_n;
  logic [CAPACITY-1:0]   sel, first, below;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [DATA_WIDTH-1:0] hit_val;
  logic [63:0]           head_key_w, head_nv_w;
  logic                  dump_last;

  // low DATA_WIDTH bits of the 32-bit fields
  assign head_key_w = 64'(cmd_head.key);
  assign head_nv_w  = 64'(cmd_head.new_value);
  assign head_key   = head_key_w[DATA_WIDTH-1:0];
  assign head_nv    = head_nv_w[DATA_WIDTH-1:0];

  function automatic logic [31:0] to_out(input logic [DATA_WIDTH-1:0] d);
    logic [63:0] w;
    w = 64'(d);
    return w[31:0];
  endfunction

  function automatic logic [4:0] to_pos(input logic [IDX_W-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[4:0];
  endfunction

  // neighbor taps of the cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
    if (g < CAPACITY - 1) begin : g_up
      assign from_up[g] = cells_r[g+1];
    end else begin : g_up_end
      assign from_up[g] = cells_r[g];
    end
    if (g > 0) begin : g_dn
      assign from_dn[g] = cells_r[g-1];
    end else begin : g_dn_end
      assign from_dn[g] = cells_r[g];
    end
  end

  // per-cell compare against the queued key; the slot just past the
  // end counts as not smaller so an insert appends there
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      eq_n[i] = (i < int'(count_r)) && (cells_r[i] == head_key);
      ge_n[i] = ((i < int'(count_r)) &&
                 ($signed(cells_r[i]) >= $signed(head_key))) ||
                (i == int'(count_r));
    end
  end

  // first flagged cell, its index and its value
  always_comb begin
    sel     = (op_r == OP_INSERT) ? ge_r : eq_r;
    first   = sel & (~sel + CAPACITY'(1));
    below   = first - CAPACITY'(1);
    hit     = |sel;
    hit_idx = '0;
    hit_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
        hit_val = hit_val | cells_r[i];
      end
    end
  end

  assign dump_last = (CNT_W'(dcnt_r) + CNT_W'(1)) == count_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_r == OP_DUMP && count_r != '0) begin
          state_nxt = S_DUMP;
        end else if (!res_full) begin
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (!res_full && dump_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and cell updates
  always_comb begin
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    res.status   = STATUS_OK;
    res.value    = '0;
    res.position = '0;
    res.last     = 1'b1;
    count_nxt    = count_r;
    dcnt_nxt     = dcnt_r;
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
    end
    case (state_r)
      S_IDLE: begin
        cmd_pop = !cmd_empty;
      end
      S_EXEC: begin
        dcnt_nxt = '0;
        case (op_r)
          OP_INSERT: begin
            res.value = to_out(key_r);
            if (count_r == CNT_W'(CAPACITY)) begin
              res.status = STATUS_FULL;
            end else begin
              res.position = to_pos(hit_idx);
              if (!res_full) begin
                count_nxt = count_r + CNT_W'(1);
                for (int i = 0; i < CAPACITY; i++) begin
                  if (first[i]) begin
                    cells_nxt[i] = key_r;
                  end else if (!below[i]) begin
                    cells_nxt[i] = from_dn[i];
                  end
                end
              end
            end
            res_push = !res_full;
          end
          OP_DELETE, OP_MODIFY, OP_SEARCH: begin
            res.value = to_out(key_r);
            if (count_r == '0) begin
              res.status = STATUS_EMPTY;
            end else if (!hit) begin
              res.status = STATUS_NOT_FOUND;
            end else begin
              res.value    = to_out(hit_val);
              res.position = to_pos(hit_idx);
              if (!res_full && op_r == OP_DELETE) begin
                count_nxt = count_r - CNT_W'(1);
                for (int i = 0; i < CAPACITY; i++) begin
                  if (!below[i]) begin
                    cells_nxt[i] = from_up[i];
                  end
                end
              end else if (!res_full && op_r == OP_MODIFY) begin
                for (int i = 0; i < CAPACITY; i++) begin
                  if (first[i]) begin
                    cells_nxt[i] = nv_r;
                  end
                end
              end
            end
            res_push = !res_full;
          end
          OP_CLEAR: begin
            res_push = !res_full;
            if (!res_full) begin
              count_nxt = '0;
            end
          end
          OP_DUMP: begin
            // a non-empty list is streamed from the dump state
            if (count_r == '0) begin
              res.status = STATUS_EMPTY;
              res_push   = !res_full;
            end
          end
          default: ;
        endcase
      end
      S_DUMP: begin
        res.value    = to_out(cells_r[0]);
        res.position = to_pos(dcnt_r);
        res.last     = dump_last;
        res_push     = !res_full;
        if (!res_full) begin
          dcnt_nxt = dcnt_r + IDX_W'(1);
          // rotate the live part of the chain by one toward the head
          for (int i = 0; i < CAPACITY; i++) begin
            if (i + 1 < int'(count_r)) begin
              cells_nxt[i] = from_up[i];
            end else if (i + 1 == int'(count_r)) begin
              cells_nxt[i] = cells_r[0];
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  // cells and the captured command, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
    if (cmd_pop) begin
      op_r  <= cmd_head.op;
      key_r <= head_key;
      nv_r  <= head_nv;
      eq_r  <= eq_n;
      ge_r  <= ge_n;
    end
  end

endmodule

// File: rtl/sorted_integer_list_engine.sv
// Top level of the sorted integer list engine.
// Keeps up to CAPACITY signed DATA_WIDTH-bit entries in ascending order and
// runs insert, delete, clear, modify, search and dump commands from a queue-like
// input (push/full) to a queue-like result side (empty/pop). Every command but
// dump is taken as the key is compared against all cells at once and the flags
// captured; the engine then picks the first flagged cell, shifts or rewrites the
// chain and writes the single result. A dump gives one result per cycle while
// the result queue has room, as the chain rotates past its head; an empty dump
// gives one result. The per-cell compare and the first-match pick across the
// chain set the cycle time. Two-deep queues sit on the command and result sides,
// so input is taken while results wait. Codes 6 and 7 are taken and dropped with
// no result. Positions are reported modulo 32 and values in their low 32 bits.
module sorted_integer_list_engine #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_new_value,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_value,
  output logic [4:0]         out_position,
  output logic               out_last
);
  import sile_pkg::*;

  cmd_t cmd_head;
  logic cmd_empty, cmd_pop;
  res_t res, out_item;
  logic res_push, res_full;
  logic [$bits(res_t)-1:0] out_bits;

  sile_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_command   (in_command),
    .in_key       ($unsigned(in_key)),
    .in_new_value ($unsigned(in_new_value)),
    .cmd_head     (cmd_head),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop)
  );

  sile_back #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_head  (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  sile_fifo #(
    .WIDTH ($bits(res_t))
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_bits),
    .empty   (empty)
  );

  assign out_item     = res_t'(out_bits);
  assign out_status   = out_item.status;
  assign out_value    = $signed(out_item.value);
  assign out_position = out_item.position;
  assign out_last     = out_item.last;

  // engine never writes a result into a full result queue
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result written into full queue");

  // engine only takes a command that is there
  a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from empty queue");

  // a command taken from the queue is always followed by a busy engine
  a_cmd_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> !cmd_pop)
    else $error("engine took two commands back to back");

  // reset leaves the result queue empty and the command queue with room
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule
